### sv/pte_pkg.sv
// Shared types, constants and helper functions for the stylus tilt block.
// Used by the top level and the CORDIC cell; depends on nothing.
package pte_pkg;

  typedef struct packed {
    logic signed [15:0] x_tilt;
    logic signed [15:0] y_tilt;
  } pte_in_t;

  typedef struct packed {
    logic signed [15:0] direction;
    logic [13:0]        elevation;
  } pte_out_t;

  typedef enum logic [1:0] {
    CFG_MAX_TILT_X = 2'd0,
    CFG_MAX_TILT_Y = 2'd1,
    CFG_NORMALIZE  = 2'd2
  } pte_cfg_t;

  // Q30 angles and vectors inside the CORDIC
  localparam int ANG_W = 34;

  typedef struct packed {
    logic signed [ANG_W-1:0] xv;
    logic signed [ANG_W-1:0] yv;
    logic signed [ANG_W-1:0] z;
  } pte_vec_t;

  localparam logic signed [ANG_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

  localparam logic [14:0] MAX_TILT_RST = 15'd15360;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:  a = 34'sd843314856;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043836;
      5'd3:  a = 34'sd133525158;
      5'd4:  a = 34'sd67021686;
      5'd5:  a = 34'sd33543515;
      5'd6:  a = 34'sd16775850;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194282;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048575;
      5'd11: a = 34'sd524287;
      5'd12: a = 34'sd262143;
      5'd13: a = 34'sd131071;
      5'd14: a = 34'sd65535;
      5'd15: a = 34'sd32767;
      5'd16: a = 34'sd16383;
      5'd17: a = 34'sd8191;
      5'd18: a = 34'sd4095;
      5'd19: a = 34'sd2047;
      5'd20: a = 34'sd1023;
      5'd21: a = 34'sd511;
      5'd22: a = 34'sd255;
      5'd23: a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Quarter turn into the right half plane before the stages
  function automatic pte_vec_t pre_rotate(input pte_vec_t v);
    pte_vec_t r;
    r   = v;
    r.z = '0;
    if (v.xv[ANG_W-1]) begin
      if (!v.yv[ANG_W-1] && (v.yv != '0)) begin
        r.xv = v.yv;
        r.yv = -v.xv;
        r.z  = HALF_PI_Q30;
      end else begin
        r.xv = -v.yv;
        r.yv = v.xv;
        r.z  = -HALF_PI_Q30;
      end
    end
    return r;
  endfunction

endpackage

### sv/pen_tilt_to_direction_elevation.sv
// Stylus tilt to direction and elevation: top level and pipeline glue.
// Depends on pte_pkg, pte_div_cell, pte_sqrt_cell and pte_cordic_cell.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one tilt sample (X, Y).
//   Result channel out_valid/out_stall/out_data carries direction (Q3.13)
//   and elevation (Q1.13), in radians or fractions when normalize is set.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the two
//   full-scale registers and the normalize bit; cfg_ready is always high.
//   Every sample runs through one long pipeline: 30 divide cells, a
//   squaring stage, 30 more divide cells, 31 square-root cells,
//   CORDIC_STAGES CORDIC cells, a multiply stage and the output register.
//   One request is taken every cycle while the receiver is not stalling.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall goes high in the same cycle.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (full scale 15360 on both axes, radians).
module pen_tilt_to_direction_elevation #(
  parameter int FRAC_BITS     = 13,
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pte_pkg::pte_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pte_pkg::pte_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [14:0]       cfg_data
);

  localparam int AW = pte_pkg::ANG_W;
  localparam int D1 = 30;
  localparam int D2 = 30;
  localparam int SQ = 31;
  localparam int NC = CORDIC_STAGES;
  localparam int L  = D1 + 1 + D2 + SQ + NC + 2;
  localparam int SH = 30 - FRAC_BITS;

  // ---------------- configuration
  logic [14:0] max_x_r, max_y_r;
  logic        norm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= pte_pkg::MAX_TILT_RST;
      max_y_r <= pte_pkg::MAX_TILT_RST;
      norm_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (pte_pkg::pte_cfg_t'(cfg_index))
        pte_pkg::CFG_MAX_TILT_X: max_x_r <= cfg_data;
        pte_pkg::CFG_MAX_TILT_Y: max_y_r <= cfg_data;
        pte_pkg::CFG_NORMALIZE:  norm_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control
  logic [L-1:0] vld_r;
  logic         adv;

  assign out_valid = vld_r[L-1];
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[L-2:0], in_valid};
  end

  // ---------------- ratio dividers
  logic [15:0] ax, ay;
  logic [3:0]  flg_in;

  always_comb begin
    ax = in_data.x_tilt[15] ? 16'(~in_data.x_tilt + 16'sd1) : 16'(in_data.x_tilt);
    ay = in_data.y_tilt[15] ? 16'(~in_data.y_tilt + 16'sd1) : 16'(in_data.y_tilt);
    // zero tilt wins over saturation
    flg_in = {ax == '0, ax >= {1'b0, max_x_r}, ay == '0, ay >= {1'b0, max_y_r}};
  end

  logic [14:0] du_rem [D1+1];
  logic [14:0] du_den [D1+1];
  logic [29:0] du_q   [D1+1];
  logic [14:0] dv_rem [D1+1];
  logic [14:0] dv_den [D1+1];
  logic [29:0] dv_q   [D1+1];
  pte_pkg::pte_in_t d1_smp_r [D1];
  logic [3:0]       d1_flg_r [D1];

  assign du_rem[0] = ax[14:0];
  assign du_den[0] = max_x_r;
  assign du_q[0]   = '0;
  assign dv_rem[0] = ay[14:0];
  assign dv_den[0] = max_y_r;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < D1; k++) begin : g_d1
    pte_div_cell #(.W(15), .QW(30)) u_du (
      .clk(clk), .en(adv),
      .rem_i(du_rem[k]), .den_i(du_den[k]), .q_i(du_q[k]),
      .rem_o(du_rem[k+1]), .den_o(du_den[k+1]), .q_o(du_q[k+1])
    );
    pte_div_cell #(.W(15), .QW(30)) u_dv (
      .clk(clk), .en(adv),
      .rem_i(dv_rem[k]), .den_i(dv_den[k]), .q_i(dv_q[k]),
      .rem_o(dv_rem[k+1]), .den_o(dv_den[k+1]), .q_o(dv_q[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_smp_r[0] <= in_data;
      d1_flg_r[0] <= flg_in;
      for (int k = 1; k < D1; k++) begin
        d1_smp_r[k] <= d1_smp_r[k-1];
        d1_flg_r[k] <= d1_flg_r[k-1];
      end
    end
  end

  // ---------------- squares
  logic [30:0] u, v, mn;
  logic [3:0]  fl;
  logic [61:0] uu_r, vv_r, mm_r;
  pte_pkg::pte_in_t m_smp_r;

  always_comb begin
    fl = d1_flg_r[D1-1];
    u  = fl[3] ? '0 : (fl[2] ? 31'(pte_pkg::ONE_Q30) : {1'b0, du_q[D1]});
    v  = fl[1] ? '0 : (fl[0] ? 31'(pte_pkg::ONE_Q30) : {1'b0, dv_q[D1]});
    mn = (u < v) ? u : v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uu_r    <= 62'(u) * 62'(u);
      vv_r    <= 62'(v) * 62'(v);
      mm_r    <= 62'(mn) * 62'(mn);
      m_smp_r <= d1_smp_r[D1-1];
    end
  end

  // ---------------- cos^2 divider
  logic [31:0] num, den;
  logic        c2_one;

  always_comb begin
    num    = uu_r[61:30] + vv_r[61:30];
    den    = 32'(pte_pkg::ONE_Q30) + mm_r[61:30];
    c2_one = num >= den;
  end

  logic [31:0] dc_rem [D2+1];
  logic [31:0] dc_den [D2+1];
  logic [29:0] dc_q   [D2+1];
  pte_pkg::pte_in_t d2_smp_r [D2];
  logic             d2_one_r [D2];

  assign dc_rem[0] = num;
  assign dc_den[0] = den;
  assign dc_q[0]   = '0;

  for (genvar k = 0; k < D2; k++) begin : g_d2
    pte_div_cell #(.W(32), .QW(30)) u_dc (
      .clk(clk), .en(adv),
      .rem_i(dc_rem[k]), .den_i(dc_den[k]), .q_i(dc_q[k]),
      .rem_o(dc_rem[k+1]), .den_o(dc_den[k+1]), .q_o(dc_q[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_smp_r[0] <= m_smp_r;
      d2_one_r[0] <= c2_one;
      for (int k = 1; k < D2; k++) begin
        d2_smp_r[k] <= d2_smp_r[k-1];
        d2_one_r[k] <= d2_one_r[k-1];
      end
    end
  end

  // ---------------- square roots for cos and sin
  logic [30:0] c2, s2;

  always_comb begin
    c2 = d2_one_r[D2-1] ? 31'(pte_pkg::ONE_Q30) : {1'b0, dc_q[D2]};
    s2 = 31'(pte_pkg::ONE_Q30) - c2;
  end

  logic [60:0] sc_rem  [SQ+1];
  logic [30:0] sc_root [SQ+1];
  logic [60:0] ss_rem  [SQ+1];
  logic [30:0] ss_root [SQ+1];
  pte_pkg::pte_in_t sq_smp_r [SQ];

  assign sc_rem[0]  = {c2, 30'b0};
  assign sc_root[0] = '0;
  assign ss_rem[0]  = {s2, 30'b0};
  assign ss_root[0] = '0;

  for (genvar j = 0; j < SQ; j++) begin : g_sq
    pte_sqrt_cell #(.K(SQ-1-j), .VW(61), .RW(31)) u_sc (
      .clk(clk), .en(adv),
      .rem_i(sc_rem[j]), .root_i(sc_root[j]),
      .rem_o(sc_rem[j+1]), .root_o(sc_root[j+1])
    );
    pte_sqrt_cell #(.K(SQ-1-j), .VW(61), .RW(31)) u_ss (
      .clk(clk), .en(adv),
      .rem_i(ss_rem[j]), .root_i(ss_root[j]),
      .rem_o(ss_rem[j+1]), .root_o(ss_root[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_smp_r[0] <= d2_smp_r[D2-1];
      for (int k = 1; k < SQ; k++) sq_smp_r[k] <= sq_smp_r[k-1];
    end
  end

  // ---------------- CORDIC: direction and elevation lanes
  pte_pkg::pte_in_t  smp;
  pte_pkg::pte_vec_t dvec, evec;
  pte_pkg::pte_vec_t dir_c [NC+1];
  pte_pkg::pte_vec_t elv_c [NC+1];
  logic              dz_r  [NC];

  always_comb begin
    smp     = sq_smp_r[SQ-1];
    dvec.xv = AW'(smp.y_tilt) <<< 14;
    dvec.yv = -(AW'(smp.x_tilt) <<< 14);
    dvec.z  = '0;
    evec.xv = AW'(sc_root[SQ]);
    evec.yv = AW'(ss_root[SQ]);
    evec.z  = '0;
  end

  assign dir_c[0] = pte_pkg::pre_rotate(dvec);
  assign elv_c[0] = pte_pkg::pre_rotate(evec);

  for (genvar i = 0; i < NC; i++) begin : g_cor
    pte_cordic_cell #(.I(i)) u_cd (
      .clk(clk), .en(adv), .vec_i(dir_c[i]), .vec_o(dir_c[i+1])
    );
    pte_cordic_cell #(.I(i)) u_ce (
      .clk(clk), .en(adv), .vec_i(elv_c[i]), .vec_o(elv_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz_r[0] <= (smp.x_tilt == '0) && (smp.y_tilt == '0);
      for (int k = 1; k < NC; k++) dz_r[k] <= dz_r[k-1];
    end
  end

  // ---------------- clamp and scale
  logic signed [AW-1:0] dr, dcl;
  logic signed [AW-1:0] ez;
  logic [30:0]          ecl;
  logic signed [AW-1:0] dc_r;
  logic [30:0]          ec_r;
  logic signed [66:0]   pd_r;
  logic [63:0]          pe_r;

  always_comb begin
    dr = dz_r[NC-1] ? '0 : dir_c[NC].z;
    if (dr < -pte_pkg::PI_Q30)     dcl = -pte_pkg::PI_Q30;
    else if (dr > pte_pkg::PI_Q30) dcl = pte_pkg::PI_Q30;
    else                           dcl = dr;
    ez = elv_c[NC].z;
    if (ez[AW-1])                         ecl = '0;
    else if (ez > pte_pkg::HALF_PI_Q30)   ecl = 31'(pte_pkg::HALF_PI_Q30);
    else                                  ecl = ez[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r <= dcl;
      ec_r <= ecl;
      pd_r <= {{33{dcl[AW-1]}}, dcl} * $signed({35'b0, pte_pkg::INV_TWO_PI_Q32});
      pe_r <= {33'b0, ecl} * {32'b0, pte_pkg::TWO_OVER_PI_Q32};
    end
  end

  // ---------------- output rounding and register
  logic signed [35:0] dsel, esel, dnorm, drnd, ernd;
  logic [31:0]        enorm;
  pte_pkg::pte_out_t  res, out_data_r;

  always_comb begin
    dnorm = {pd_r[66], pd_r[66:32]} + 36'sd536870912;
    enorm = pe_r[63:32];
    if (norm_r) begin
      if (dnorm[35])                               dsel = '0;
      else if (dnorm > 36'(pte_pkg::ONE_Q30))      dsel = 36'(pte_pkg::ONE_Q30);
      else                                         dsel = dnorm;
      if (enorm > 32'(pte_pkg::ONE_Q30))           esel = 36'(pte_pkg::ONE_Q30);
      else                                         esel = {4'b0, enorm};
    end else begin
      dsel = {{2{dc_r[AW-1]}}, dc_r};
      esel = {5'b0, ec_r};
    end
    drnd          = (dsel + (36'sd1 <<< (SH - 1))) >>> SH;
    ernd          = (esel + (36'sd1 <<< (SH - 1))) >>> SH;
    res.direction = drnd[15:0];
    res.elevation = ernd[13:0];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res;
  end

  assign out_data = out_data_r;

endmodule

### sv/pte_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on nothing; chained in the top level.
module pte_div_cell #(
  parameter int W  = 15,
  parameter int QW = 30
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  rem_i,
  input  logic [W-1:0]  den_i,
  input  logic [QW-1:0] q_i,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  den_o,
  output logic [QW-1:0] q_o
);

  logic [W:0]    rem2;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [W-1:0]  rem_r, den_r;
  logic [QW-1:0] q_r;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, den_i};
    ge      = rem2 >= {1'b0, den_i};
    rem_nxt = ge ? diff[W-1:0] : rem2[W-1:0];
    q_nxt   = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;

endmodule

### sv/pte_sqrt_cell.sv
// One bit of a floor integer square root; the cell for root bit K.
// Depends on nothing; chained in the top level, highest bit first.
module pte_sqrt_cell #(
  parameter int K  = 30,
  parameter int VW = 61,
  parameter int RW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  output logic [VW-1:0] rem_o,
  output logic [RW-1:0] root_o
);

  localparam int TW = 2 * RW + 1;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_w;
  logic          ge;
  logic [VW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic [VW-1:0] rem_r;
  logic [RW-1:0] root_r;

  // (root + 2^K)^2 - root^2
  always_comb begin
    trial    = ({{(TW-RW){1'b0}}, root_i} << (K + 1)) + (TW'(1) << (2 * K));
    rem_w    = {{(TW-VW){1'b0}}, rem_i};
    ge       = rem_w >= trial;
    rem_nxt  = ge ? VW'(rem_w - trial) : rem_i;
    root_nxt = ge ? (root_i | (RW'(1) << K)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

### sv/pte_cordic_cell.sv
// One CORDIC vectoring micro-rotation, stage I.
// Depends on pte_pkg for the vector type and the arctangent constants.
module pte_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk,
  input  logic             en,
  input  pte_pkg::pte_vec_t vec_i,
  output pte_pkg::pte_vec_t vec_o
);

  localparam logic signed [pte_pkg::ANG_W-1:0] ATAN = pte_pkg::atan_q30(5'(I));

  logic signed [pte_pkg::ANG_W-1:0] dx, dy;
  logic              pos;
  pte_pkg::pte_vec_t vec_nxt;
  pte_pkg::pte_vec_t vec_r;

  always_comb begin
    dx  = vec_i.yv >>> I;
    dy  = vec_i.xv >>> I;
    pos = !vec_i.yv[pte_pkg::ANG_W-1] && (vec_i.yv != '0);
    if (pos) begin
      vec_nxt.xv = vec_i.xv + dx;
      vec_nxt.yv = vec_i.yv - dy;
      vec_nxt.z  = vec_i.z + ATAN;
    end else begin
      vec_nxt.xv = vec_i.xv - dx;
      vec_nxt.yv = vec_i.yv + dy;
      vec_nxt.z  = vec_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) vec_r <= vec_nxt;
  end

  assign vec_o = vec_r;

endmodule
